>>> src/tsd_pkg.sv
// Package for the TGA stream decoder: beat types, phase and result codes,
// palette sizing. Used by every module of the block except tsd_ram.
package tsd_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int PAL_DW          = 24;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_IDSKIP,
    PH_CMAP,
    PH_PKTHDR,
    PH_PIXEL,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    KIND_INFO      = 3'd0,
    KIND_PIXEL     = 3'd1,
    KIND_BAD_TYPE  = 3'd2,
    KIND_BAD_DEPTH = 3'd3,
    KIND_BAD_CMAP  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  chan0;
    logic [7:0]  chan1;
    logic [7:0]  chan2;
    logic [7:0]  chan3;
    logic [7:0]  run_length;
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  orientation;
    logic        last;
  } out_beat_t;

  // Result leaving the parser; pal_sel asks the output stage to take the
  // colour from the palette memory (or zero when the entry is not loaded).
  typedef struct packed {
    logic      valid;
    logic      pal_sel;
    logic      pal_hit;
    out_beat_t beat;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] waddr;
    logic [PAL_DW-1:0] wdata;
  } pal_wr_t;

endpackage

>>> src/tga_stream_decoder.sv
// TGA stream decoder top level: one file byte per beat in, header/pixel
// results out via the lookup stage register and then the output register.
// Throughput: one byte per cycle unless output back-pressure holds input; an RLE
// repeat run that wraps past the next row stalls input while the shift-subtract
// divider places it. Palette: 24-bit entries in a RAM with one write and one
// read port; read data is registered, following the index in the next cycle.
// Reset: asynchronous, active low; control state and palette valid bits clear.
module tga_stream_decoder import tsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  logic              accept;
  logic              busy;
  logic              free;
  res_t              res;
  pal_wr_t           pal_wr;
  logic [PAL_AW-1:0] rd_idx;
  logic [PAL_AW-1:0] raddr;
  logic [PAL_DW-1:0] rdata;

  // Take a beat when the divider is idle and the lookup stage can move.
  assign in_ready_o = !busy && free;
  assign accept     = in_valid_i && in_ready_o;

  tsd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (in_beat_i),
    .busy_o   (busy),
    .res_o    (res),
    .pal_wr_o (pal_wr),
    .rd_idx_o (rd_idx)
  );

  tsd_ram #(
    .WIDTH (PAL_DW),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_wr.we),
    .waddr_i (pal_wr.waddr),
    .wdata_i (pal_wr.wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tsd_outstage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .res_i       (res),
    .rd_idx_i    (rd_idx),
    .rdata_i     (rdata),
    .raddr_o     (raddr),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  // Divider running means no byte may enter.
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o) else $error("input taken while divider busy");

  // A pixel beat always stands for at least one pixel.
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.kind == KIND_PIXEL |-> out_beat_o.run_length != 8'd0)
    else $error("pixel beat with zero run");

  // Header errors always close the image.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.kind == KIND_BAD_TYPE || out_beat_o.kind == KIND_BAD_DEPTH ||
                    out_beat_o.kind == KIND_BAD_CMAP) |-> out_beat_o.last)
    else $error("error beat without last");

endmodule

>>> src/tsd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/tsd_parser.sv
// Byte parser: header, ID skip, colour map load, packet and pixel decode,
// run placement with a shift-subtract divider for long wraps.
// Depends on tsd_pkg.
module tsd_parser import tsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  in_beat_t          beat_i,
  output logic              busy_o,
  output res_t              res_o,
  output pal_wr_t           pal_wr_o,
  output logic [PAL_AW-1:0] rd_idx_o
);

  localparam logic [4:0] HdrIdLen   = 5'd0;
  localparam logic [4:0] HdrMapType = 5'd1;
  localparam logic [4:0] HdrImgType = 5'd2;
  localparam logic [4:0] HdrMapFLo  = 5'd3;
  localparam logic [4:0] HdrMapFHi  = 5'd4;
  localparam logic [4:0] HdrMapLLo  = 5'd5;
  localparam logic [4:0] HdrMapLHi  = 5'd6;
  localparam logic [4:0] HdrMapBits = 5'd7;
  localparam logic [4:0] HdrWLo     = 5'd12;
  localparam logic [4:0] HdrWHi     = 5'd13;
  localparam logic [4:0] HdrHLo     = 5'd14;
  localparam logic [4:0] HdrHHi     = 5'd15;
  localparam logic [4:0] HdrBpp     = 5'd16;
  localparam logic [4:0] HdrDesc    = 5'd17;

  phase_e      phase_q, phase_d;
  logic [15:0] bc_q, bc_d;
  logic [7:0]  id_len_q, id_len_d, map_type_q, map_type_d, img_type_q, img_type_d;
  logic [15:0] map_first_q, map_first_d, map_len_q, map_len_d;
  logic [7:0]  map_bits_q, map_bits_d, bpp_q, bpp_d;
  logic [15:0] w_q, w_d, h_q, h_d;
  logic [1:0]  orient_q, orient_d;
  logic [31:0] area_q, area_d, rest_q, rest_d;
  logic [7:0]  pkt_rem_q, pkt_rem_d;
  logic        pkt_rep_q, pkt_rep_d;
  logic [7:0]  pb_q [3];
  logic [7:0]  pb_d [3];
  logic [15:0] col_q, col_d, row_q, row_d;
  logic [15:0] ent_q, ent_d, left_q, left_d;
  logic [1:0]  comp_q, comp_d;
  logic [7:0]  e0_q, e0_d, e1_q, e1_d;
  logic [PALETTE_ENTRIES-1:0] loaded_q, loaded_d;
  logic        busy_q, busy_d;
  logic [2:0]  dstep_q, dstep_d;
  logic [16:0] drem_q, drem_d;
  logic [7:0]  dquo_q, dquo_d;

  phase_e      ph;
  phase_e      pix_phase, map_phase;
  logic [15:0] bc;
  logic [7:0]  b;
  logic        is_rle;
  logic [4:0]  bb;
  logic        emit;
  logic [7:0]  run;
  logic        last;
  logic [7:0]  run_out;
  logic [16:0] total;
  logic [17:0] w2;
  logic [23:0] w_sh;
  logic [16:0] rem_n;
  logic [7:0]  quo_n;
  logic        idx_ok;
  logic        ent_ok;
  logic [15:0] bc_n;

  assign b      = beat_i.byte_value;
  assign ph     = beat_i.start_of_file ? PH_HEADER : phase_q;
  assign bc     = beat_i.start_of_file ? 16'd0 : bc_q;
  assign is_rle = img_type_q >= 8'd9;
  assign bb     = bpp_q[7:3];
  assign bc_n   = bc + 16'd1;
  assign pix_phase = is_rle ? PH_PKTHDR : PH_PIXEL;
  assign map_phase = (map_type_q == 8'd1 && map_len_q != 16'd0) ? PH_CMAP : pix_phase;
  assign idx_ok = {1'b0, b} < 9'(PALETTE_ENTRIES);
  assign ent_ok = ent_q < 16'(PALETTE_ENTRIES);
  assign rd_idx_o = b[PAL_AW-1:0];
  assign busy_o = busy_q;

  always_comb begin
    w_sh  = 24'(w_q) << dstep_q;
    rem_n = drem_q;
    quo_n = dquo_q;
    if ({7'd0, drem_q} >= w_sh) begin
      rem_n = drem_q - w_sh[16:0];
      quo_n[dstep_q] = 1'b1;
    end
  end

  always_comb begin
    phase_d = phase_q; bc_d = bc_q;
    id_len_d = id_len_q; map_type_d = map_type_q; img_type_d = img_type_q;
    map_first_d = map_first_q; map_len_d = map_len_q; map_bits_d = map_bits_q;
    bpp_d = bpp_q; w_d = w_q; h_d = h_q; orient_d = orient_q;
    area_d = area_q; rest_d = rest_q;
    pkt_rem_d = pkt_rem_q; pkt_rep_d = pkt_rep_q; pb_d = pb_q;
    col_d = col_q; row_d = row_q;
    ent_d = ent_q; left_d = left_q; comp_d = comp_q; e0_d = e0_q; e1_d = e1_q;
    loaded_d = loaded_q;
    busy_d = busy_q; dstep_d = dstep_q; drem_d = drem_q; dquo_d = dquo_q;
    res_o = '0;
    pal_wr_o = '0;
    emit = 1'b0;
    run = 8'd1;
    last = 1'b0;
    run_out = 8'd1;
    total = '0;
    w2 = '0;

    if (busy_q) begin
      drem_d  = rem_n;
      dquo_d  = quo_n;
      dstep_d = dstep_q - 3'd1;
      if (dstep_q == 3'd0) begin
        busy_d = 1'b0;
        row_d  = row_q + 16'(quo_n);
        col_d  = rem_n[15:0];
      end
    end

    if (accept_i) begin
      if (beat_i.start_of_file) begin
        loaded_d = '0;
        pkt_rem_d = '0; pkt_rep_d = 1'b0; col_d = '0; row_d = '0;
      end
      case (ph)
        PH_HEADER: begin
          bc_d = bc_n;
          phase_d = PH_HEADER;
          case (bc[4:0])
            HdrIdLen:   id_len_d = b;
            HdrMapType: map_type_d = b;
            HdrImgType: img_type_d = b;
            HdrMapFLo:  map_first_d[7:0] = b;
            HdrMapFHi:  map_first_d[15:8] = b;
            HdrMapLLo:  map_len_d[7:0] = b;
            HdrMapLHi:  map_len_d[15:8] = b;
            HdrMapBits: map_bits_d = b;
            HdrWLo:     w_d[7:0] = b;
            HdrWHi:     w_d[15:8] = b;
            HdrHLo:     h_d[7:0] = b;
            HdrHHi:     h_d[15:8] = b;
            HdrBpp: begin
              bpp_d = b;
              area_d = 32'(w_q) * 32'(h_q);
            end
            HdrDesc: begin
              res_o.valid = 1'b1;
              bc_d = '0;
              if (!(img_type_q == 8'd1 || img_type_q == 8'd2 || img_type_q == 8'd3 ||
                    img_type_q == 8'd9 || img_type_q == 8'd10 || img_type_q == 8'd11)) begin
                res_o.beat.kind = KIND_BAD_TYPE;
                res_o.beat.last = 1'b1;
                phase_d = PH_DONE;
              end else if (!(bpp_q == 8'd8 || bpp_q == 8'd24 || bpp_q == 8'd32)) begin
                res_o.beat.kind = KIND_BAD_DEPTH;
                res_o.beat.last = 1'b1;
                phase_d = PH_DONE;
              end else if (map_type_q == 8'd1 && (map_bits_q != 8'd24 ||
                           {1'b0, map_first_q} + {1'b0, map_len_q} >
                           17'(PALETTE_ENTRIES))) begin
                res_o.beat.kind = KIND_BAD_CMAP;
                res_o.beat.last = 1'b1;
                phase_d = PH_DONE;
              end else begin
                res_o.beat.kind = KIND_INFO;
                res_o.beat.image_width = w_q;
                res_o.beat.image_height = h_q;
                res_o.beat.orientation = b[5:4];
                orient_d = b[5:4];
                rest_d = area_q;
                ent_d = map_first_q; left_d = map_len_q; comp_d = '0;
                col_d = '0; row_d = '0; pkt_rem_d = '0; pkt_rep_d = 1'b0;
                if (w_q == 16'd0 || h_q == 16'd0) begin
                  res_o.beat.last = 1'b1;
                  phase_d = PH_DONE;
                end else if (id_len_q != 8'd0) begin
                  phase_d = PH_IDSKIP;
                end else begin
                  phase_d = map_phase;
                end
              end
            end
            default: ;
          endcase
        end
        PH_IDSKIP: begin
          bc_d = bc_n;
          if (bc_n >= {8'd0, id_len_q}) begin
            bc_d = '0;
            phase_d = map_phase;
          end
        end
        PH_CMAP: begin
          case (comp_q)
            2'd0: begin e0_d = b; comp_d = 2'd1; end
            2'd1: begin e1_d = b; comp_d = 2'd2; end
            default: begin
              comp_d = 2'd0;
              if (ent_ok) begin
                pal_wr_o.we = 1'b1;
                pal_wr_o.waddr = ent_q[PAL_AW-1:0];
                pal_wr_o.wdata = {b, e1_q, e0_q};
                loaded_d[ent_q[PAL_AW-1:0]] = 1'b1;
              end
              ent_d = ent_q + 16'd1;
              left_d = left_q - 16'd1;
              if (left_q == 16'd1) begin
                bc_d = '0;
                phase_d = pix_phase;
              end
            end
          endcase
        end
        PH_PKTHDR: begin
          pkt_rem_d = {1'b0, b[6:0]} + 8'd1;
          pkt_rep_d = b[7];
          bc_d = '0;
          phase_d = PH_PIXEL;
        end
        PH_PIXEL: begin
          if (bc[1:0] != 2'd3) begin
            pb_d[bc[1:0]] = b;
          end
          bc_d = bc_n;
          if (bc_n >= {11'd0, bb}) begin
            bc_d = '0;
            emit = 1'b1;
            if (is_rle) begin
              if (pkt_rep_q) begin
                run = pkt_rem_q;
                pkt_rem_d = '0;
                phase_d = PH_PKTHDR;
              end else begin
                pkt_rem_d = pkt_rem_q - 8'd1;
                if (pkt_rem_q == 8'd1) phase_d = PH_PKTHDR;
              end
            end
          end
        end
        default: ;
      endcase

      if (emit) begin
        last    = {24'd0, run} >= rest_q;
        run_out = last ? rest_q[7:0] : run;
        res_o.valid = 1'b1;
        res_o.beat.kind = KIND_PIXEL;
        res_o.beat.run_length = run_out;
        res_o.beat.dest_x = orient_q[0] ? (w_q - 16'd1 - col_q) : col_q;
        res_o.beat.dest_y = orient_q[1] ? row_q : (h_q - 16'd1 - row_q);
        res_o.beat.image_width = w_q;
        res_o.beat.image_height = h_q;
        res_o.beat.orientation = orient_q;
        res_o.beat.last = last;
        res_o.beat.chan3 = 8'hff;
        if (bb == 5'd1) begin
          res_o.beat.chan0 = b;
          res_o.beat.chan1 = b;
          res_o.beat.chan2 = b;
          res_o.pal_sel = map_type_q == 8'd1;
          res_o.pal_hit = idx_ok && loaded_q[b[PAL_AW-1:0]];
        end else begin
          res_o.beat.chan0 = pb_q[0];
          res_o.beat.chan1 = pb_q[1];
          res_o.beat.chan2 = (bb == 5'd3) ? b : pb_q[2];
          if (bb == 5'd4) res_o.beat.chan3 = b;
        end
        // Advance the scan position; long wraps go to the divider.
        total = {1'b0, col_q} + 17'(run);
        w2    = {2'b0, w_q} << 1;
        if (last) begin
          phase_d = PH_DONE;
        end else begin
          rest_d = rest_q - 32'(run);
          if (total < {1'b0, w_q}) begin
            col_d = total[15:0];
          end else if ({1'b0, total} < w2) begin
            row_d = row_q + 16'd1;
            col_d = 16'(total - {1'b0, w_q});
          end else begin
            busy_d = 1'b1;
            drem_d = total;
            dquo_d = '0;
            dstep_d = 3'd7;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      bc_q <= '0;
      pkt_rem_q <= '0;
      pkt_rep_q <= 1'b0;
      col_q <= '0;
      row_q <= '0;
      loaded_q <= '0;
      busy_q <= 1'b0;
      dstep_q <= '0;
    end else begin
      phase_q <= phase_d;
      bc_q <= bc_d;
      pkt_rem_q <= pkt_rem_d;
      pkt_rep_q <= pkt_rep_d;
      col_q <= col_d;
      row_q <= row_d;
      loaded_q <= loaded_d;
      busy_q <= busy_d;
      dstep_q <= dstep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_len_q <= id_len_d; map_type_q <= map_type_d; img_type_q <= img_type_d;
    map_first_q <= map_first_d; map_len_q <= map_len_d; map_bits_q <= map_bits_d;
    bpp_q <= bpp_d; w_q <= w_d; h_q <= h_d; orient_q <= orient_d;
    area_q <= area_d; rest_q <= rest_d; pb_q <= pb_d;
    ent_q <= ent_d; left_q <= left_d; comp_q <= comp_d; e0_q <= e0_d; e1_q <= e1_d;
    drem_q <= drem_d; dquo_q <= dquo_d;
  end

endmodule

>>> src/tsd_outstage.sv
// Output pipeline: lookup stage waiting on palette read data, then the
// output register. Depends on tsd_pkg.
module tsd_outstage import tsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  res_t              res_i,
  input  logic [PAL_AW-1:0] rd_idx_i,
  input  logic [PAL_DW-1:0] rdata_i,
  output logic [PAL_AW-1:0] raddr_o,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_beat_t         out_beat_o
);

  logic              s1_v_q;
  res_t              s1_q;
  logic [PAL_AW-1:0] s1_idx_q;
  logic              adv;
  out_beat_t         merged;

  assign adv    = !out_valid_o || out_ready_i;
  assign free_o = !s1_v_q || adv;
  // Hold the read address while the lookup stage stalls, so data stays put.
  assign raddr_o = (s1_v_q && !adv) ? s1_idx_q : rd_idx_i;

  always_comb begin
    merged = s1_q.beat;
    if (s1_q.pal_sel) begin
      merged.chan0 = s1_q.pal_hit ? rdata_i[7:0]   : 8'd0;
      merged.chan1 = s1_q.pal_hit ? rdata_i[15:8]  : 8'd0;
      merged.chan2 = s1_q.pal_hit ? rdata_i[23:16] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (accept_i && res_i.valid) begin
        s1_v_q <= 1'b1;
      end else if (adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_v_q && adv) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && res_i.valid) begin
      s1_q <= res_i;
      s1_idx_q <= rd_idx_i;
    end
    if (s1_v_q && adv) begin
      out_beat_o <= merged;
    end
  end

endmodule
